@@ sv/detq_pkg.sv @@
package detq_pkg;

    localparam int DEPTH       = 64;
    localparam int HANDLE_BITS = 32;
    localparam int IDX_BITS    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS    = $clog2(DEPTH + 1);
    localparam int SUM_BITS    = CNT_BITS + 1;
    localparam int OP_BITS     = 2;

    typedef logic [IDX_BITS-1:0]    idx_t;
    typedef logic [CNT_BITS-1:0]    cnt_t;
    typedef logic [SUM_BITS-1:0]    sum_t;
    typedef logic [HANDLE_BITS-1:0] handle_t;

    typedef enum logic [OP_BITS-1:0] {
        OP_PUT_HEAD  = 2'd0,
        OP_PUT_TAIL  = 2'd1,
        OP_TAKE_HEAD = 2'd2,
        OP_TAKE_TAIL = 2'd3
    } op_t;

    function automatic idx_t wrap_idx(input sum_t v);
        sum_t reduced;
        reduced = v - sum_t'(DEPTH);
        if (v >= sum_t'(DEPTH))
        begin
            return idx_t'(reduced);
        end
        return idx_t'(v);
    endfunction

endpackage

@@ sv/double_ended_task_queue_top.sv @@
// Double-ended queue of task handles in a circular slot memory of DEPTH entries. Each transfer
// on the input carries one operation (put at head, put at tail, take from head, take from tail)
// and produces exactly one result transfer reporting the handle taken, whether a put into a
// full queue was dropped, and the count held afterwards. A take from an empty queue returns
// handle zero with taken_valid low. One operation is accepted per cycle; its result appears in
// the cycle after acceptance, from the registered read port of the slot memory, and the input
// keeps accepting while the result register can be emptied in the same cycle.
module double_ended_task_queue_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [detq_pkg::OP_BITS-1:0]  operation,
    input  detq_pkg::handle_t             task_handle,
    output logic                          out_valid,
    input  logic                          out_ready,
    output detq_pkg::handle_t             taken_handle,
    output logic                          taken_valid,
    output logic                          put_dropped,
    output detq_pkg::cnt_t                entry_count
);

    import detq_pkg::*;

    idx_t    front_reg, front_next;
    cnt_t    count_reg, count_next;
    logic    out_valid_reg;
    logic    take_ok_reg;
    logic    dropped_reg;
    cnt_t    count_out_reg;

    op_t     op;
    logic    accept;
    logic    full;
    logic    empty;
    logic    wr_en;
    idx_t    wr_addr;
    logic    rd_en;
    idx_t    rd_addr;
    logic    dropped_now;
    handle_t rd_data;
    idx_t    front_dec;
    idx_t    front_inc;
    idx_t    tail_put;
    idx_t    tail_take;

    assign op       = op_t'(operation);
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign full     = (count_reg == cnt_t'(DEPTH));
    assign empty    = (count_reg == '0);

    assign front_dec = (front_reg == '0) ? idx_t'(DEPTH - 1) : front_reg - idx_t'(1);
    assign front_inc = wrap_idx(sum_t'(front_reg) + sum_t'(1));
    assign tail_put  = wrap_idx(sum_t'(front_reg) + sum_t'(count_reg));
    assign tail_take = wrap_idx(sum_t'(front_reg) + sum_t'(count_reg) - sum_t'(1));

    always_comb
    begin
        front_next  = front_reg;
        count_next  = count_reg;
        wr_en       = 1'b0;
        wr_addr     = tail_put;
        rd_en       = 1'b0;
        rd_addr     = front_reg;
        dropped_now = 1'b0;
        case (op)
            OP_PUT_HEAD:
            begin
                if (full)
                begin
                    dropped_now = 1'b1;
                end
                else
                begin
                    wr_en      = accept;
                    wr_addr    = front_dec;
                    front_next = front_dec;
                    count_next = count_reg + cnt_t'(1);
                end
            end
            OP_PUT_TAIL:
            begin
                if (full)
                begin
                    dropped_now = 1'b1;
                end
                else
                begin
                    wr_en      = accept;
                    wr_addr    = tail_put;
                    count_next = count_reg + cnt_t'(1);
                end
            end
            OP_TAKE_HEAD:
            begin
                if (!empty)
                begin
                    rd_en      = accept;
                    rd_addr    = front_reg;
                    front_next = front_inc;
                    count_next = count_reg - cnt_t'(1);
                end
            end
            OP_TAKE_TAIL:
            begin
                if (!empty)
                begin
                    rd_en      = accept;
                    rd_addr    = tail_take;
                    count_next = count_reg - cnt_t'(1);
                end
            end
            default:
            begin
                front_next = front_reg;
            end
        endcase
    end

    detq_slot_ram #(
        .ENTRIES   (DEPTH),
        .ADDR_BITS (IDX_BITS),
        .DATA_BITS (HANDLE_BITS)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (task_handle),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // queue pointers and result register move together on each input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            take_ok_reg   <= 1'b0;
            dropped_reg   <= 1'b0;
            count_out_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                front_reg     <= front_next;
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
                take_ok_reg   <= rd_en;
                dropped_reg   <= dropped_now;
                count_out_reg <= count_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign taken_handle = take_ok_reg ? rd_data : '0;
    assign taken_valid  = take_ok_reg;
    assign put_dropped  = dropped_reg;
    assign entry_count  = count_out_reg;

endmodule

@@ sv/detq_slot_ram.sv @@
module detq_slot_ram #(
    parameter int ENTRIES   = 64,
    parameter int ADDR_BITS = 6,
    parameter int DATA_BITS = 32
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [DATA_BITS-1:0] wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [DATA_BITS-1:0] rd_data
);

    logic [DATA_BITS-1:0] slot_mem [ENTRIES];
    logic [DATA_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
